// File: design/yrms_pkg.sv
// ----------------------------------------------------------------------------
// yrms_pkg
// Field widths, stream packing and register indexes for the NV21 pixel to
// mean-subtracted RGB core.
// ----------------------------------------------------------------------------
package yrms_pkg;

  localparam int COL_W      = 10;
  localparam int ROW_W      = 10;
  localparam int PIX_W      = 8;
  localparam int MEAN_W     = 16;
  localparam int DIM_CFG_W  = 11;
  localparam int CH_OUT_W   = 17;
  localparam int IDX_W      = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int S_FIELDS_W = COL_W + ROW_W + 3 * PIX_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = 3 * CH_OUT_W + IDX_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEAN_RED      = 3'd0,
    REG_MEAN_GREEN    = 3'd1,
    REG_MEAN_BLUE     = 3'd2,
    REG_TARGET_WIDTH  = 3'd3,
    REG_TARGET_HEIGHT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] chroma_v;
    logic [PIX_W-1:0] chroma_u;
    logic [PIX_W-1:0] luma;
    logic [ROW_W-1:0] target_row;
    logic [COL_W-1:0] target_col;
  } pix_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]    pixel_index;
    logic [CH_OUT_W-1:0] blue_out;
    logic [CH_OUT_W-1:0] green_out;
    logic [CH_OUT_W-1:0] red_out;
  } pix_out_t;

endpackage

// File: design/yuv_pixel_to_rgb_mean_sub_core.sv
// ----------------------------------------------------------------------------
// yuv_pixel_to_rgb_mean_sub_core
// Converts one NV21 pixel (Y, U, V) to clamped RGB, subtracts a per-channel
// Q8.8 mean and computes the planar element index of the target pixel.
// ----------------------------------------------------------------------------
// The core takes one pixel per clock while the output side does not stall
// it, and gives one result per pixel, in order. An accepted pixel passes an
// input register and then a result register, with the color matrix, clamp,
// mean subtraction and index multiply between them. The input register
// keeps taking pixels while a result waits on the output, so a stall on the
// output side holds the input side only once both registers are full.
// Configuration applies to each pixel that moves into the result register
// after the write; target_height is accepted but has no effect on any result.
module yuv_pixel_to_rgb_mean_sub_core #(
  parameter int MAX_TARGET_DIM = 1024,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,

  input  logic                             cfg_wen,
  input  logic [yrms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [yrms_pkg::CFG_DATA_W-1:0]  cfg_data,

  input  logic                             s_tvalid,
  output logic                             s_tready,
  // Fields from bit 0: target_col, target_row, luma, chroma_u, chroma_v.
  input  logic [yrms_pkg::S_TDATA_W-1:0]   s_tdata,

  output logic                             m_tvalid,
  input  logic                             m_tready,
  // Fields from bit 0: red_out, green_out, blue_out, pixel_index.
  output logic [yrms_pkg::M_TDATA_W-1:0]   m_tdata
);

  localparam int TW_W   = $clog2(MAX_TARGET_DIM + 1);
  localparam int CMP_W  = (TW_W > yrms_pkg::DIM_CFG_W) ? TW_W : yrms_pkg::DIM_CFG_W;
  localparam int ACC_W  = COEF_FRAC_BITS + 12;
  localparam int PROD_W = (yrms_pkg::ROW_W + TW_W + 1 > yrms_pkg::IDX_W) ?
                          (yrms_pkg::ROW_W + TW_W + 1) : yrms_pkg::IDX_W;

  localparam longint COEF_RV_L = ((longint'(1370705) << COEF_FRAC_BITS) + 500000) / 1000000;
  localparam longint COEF_GU_L = ((longint'(698001) << COEF_FRAC_BITS) + 500000) / 1000000;
  localparam longint COEF_GV_L = ((longint'(703125) << COEF_FRAC_BITS) + 500000) / 1000000;
  localparam longint COEF_BU_L = ((longint'(1732446) << COEF_FRAC_BITS) + 500000) / 1000000;

  localparam logic signed [ACC_W-1:0] COEF_RV = ACC_W'(COEF_RV_L);
  localparam logic signed [ACC_W-1:0] COEF_GU = ACC_W'(COEF_GU_L);
  localparam logic signed [ACC_W-1:0] COEF_GV = ACC_W'(COEF_GV_L);
  localparam logic signed [ACC_W-1:0] COEF_BU = ACC_W'(COEF_BU_L);

  function automatic logic [yrms_pkg::PIX_W-1:0] clamp_ch(input logic signed [ACC_W-1:0] acc);
    logic [yrms_pkg::PIX_W-1:0] res;
    if (acc[ACC_W-1]) begin
      res = '0;
    end else if (|acc[ACC_W-2:COEF_FRAC_BITS+yrms_pkg::PIX_W]) begin
      res = '1;
    end else begin
      res = acc[COEF_FRAC_BITS+yrms_pkg::PIX_W-1:COEF_FRAC_BITS];
    end
    return res;
  endfunction

  function automatic logic [yrms_pkg::CH_OUT_W-1:0] sub_mean(
    input logic [yrms_pkg::PIX_W-1:0]  ch,
    input logic [yrms_pkg::MEAN_W-1:0] mean
  );
    return {1'b0, ch, 8'h00} - {1'b0, mean};
  endfunction

  logic [yrms_pkg::MEAN_W-1:0] mean_red;
  logic [yrms_pkg::MEAN_W-1:0] mean_green;
  logic [yrms_pkg::MEAN_W-1:0] mean_blue;
  logic [TW_W-1:0]             target_width;
  logic [CMP_W-1:0]            width_wr;

  assign width_wr = CMP_W'(cfg_data[yrms_pkg::DIM_CFG_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_red     <= '0;
      mean_green   <= '0;
      mean_blue    <= '0;
      target_width <= TW_W'(1);
    end else if (cfg_wen) begin
      case (yrms_pkg::cfg_reg_t'(cfg_index))
        yrms_pkg::REG_MEAN_RED:   mean_red   <= cfg_data;
        yrms_pkg::REG_MEAN_GREEN: mean_green <= cfg_data;
        yrms_pkg::REG_MEAN_BLUE:  mean_blue  <= cfg_data;
        yrms_pkg::REG_TARGET_WIDTH: begin
          if (width_wr > CMP_W'(MAX_TARGET_DIM)) begin
            target_width <= TW_W'(MAX_TARGET_DIM);
          end else begin
            target_width <= TW_W'(width_wr);
          end
        end
        yrms_pkg::REG_TARGET_HEIGHT: ;
        default: ;
      endcase
    end
  end

  logic              s1_valid;
  yrms_pkg::pix_in_t s1_pix;
  logic              s2_load;

  assign s2_load  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_pix <= yrms_pkg::pix_in_t'(s_tdata[yrms_pkg::S_FIELDS_W-1:0]);
    end
  end

  logic signed [7:0]       u_s;
  logic signed [7:0]       v_s;
  logic signed [ACC_W-1:0] u_ext;
  logic signed [ACC_W-1:0] v_ext;
  logic signed [ACC_W-1:0] y_base;
  logic signed [ACC_W-1:0] r_acc;
  logic signed [ACC_W-1:0] g_acc;
  logic signed [ACC_W-1:0] b_acc;
  logic [PROD_W-1:0]       idx_full;
  yrms_pkg::pix_out_t      res_next;

  assign u_s    = {~s1_pix.chroma_u[7], s1_pix.chroma_u[6:0]};
  assign v_s    = {~s1_pix.chroma_v[7], s1_pix.chroma_v[6:0]};
  assign u_ext  = ACC_W'(u_s);
  assign v_ext  = ACC_W'(v_s);
  assign y_base = $signed(ACC_W'(s1_pix.luma)) <<< COEF_FRAC_BITS;

  assign r_acc = y_base + COEF_RV * v_ext;
  assign g_acc = y_base - COEF_GU * u_ext - COEF_GV * v_ext;
  assign b_acc = y_base + COEF_BU * u_ext;

  assign idx_full = PROD_W'(s1_pix.target_row) * PROD_W'(target_width)
                  + PROD_W'(s1_pix.target_col);

  always_comb begin
    res_next.red_out     = sub_mean(clamp_ch(r_acc), mean_red);
    res_next.green_out   = sub_mean(clamp_ch(g_acc), mean_green);
    res_next.blue_out    = sub_mean(clamp_ch(b_acc), mean_blue);
    res_next.pixel_index = idx_full[yrms_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      m_tdata <= yrms_pkg::M_TDATA_W'(res_next);
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && m_tvalid && !m_tready))
    else $error("input stalled while the pipeline has room");

  assert property (@(posedge clk) disable iff (rst)
    s2_load |=> m_tvalid)
    else $error("pixel moved to the result register without a valid result");

  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> s1_valid)
    else $error("accepted pixel lost from the input register");

  assert property (@(posedge clk) disable iff (rst)
    (target_width <= TW_W'(MAX_TARGET_DIM)))
    else $error("target width above its limit");
`endif

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the NV21 pixel to mean-subtracted RGB core.
// ----------------------------------------------------------------------------
// Pixels go in on the input stream and are checked on the output stream. A
// bench-side model of the color matrix, clamp, mean subtraction and planar
// index predicts each result when its input transfer is accepted. Every
// output transfer is compared field by field against the oldest prediction.
// Directed tests cover reset values, saturating and clamping pixels, mean
// extremes, width saturation, zero width and writes to unused register
// indexes. Random traffic then runs under several idle and stall mixes, and
// one long output hold-off fills the core so that it stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  MAX_DIM        = 1024;
  localparam int  COEF_FRAC      = 16;
  localparam int  FIRST_SPARE_REG = 5;
  localparam int  RESULT_LATENCY = 4;
  localparam int  MAX_REPORTS    = 10;
  localparam int  PHASE_ITEMS    = 80;
  localparam int  HOLDOFF_CYCLES = 300;

  function automatic longint coef_fixed(input longint micro);
    return ((micro << COEF_FRAC) + 500000) / 1000000;
  endfunction

  localparam longint CR_TO_RED   = coef_fixed(1370705);
  localparam longint CB_TO_GREEN = coef_fixed(698001);
  localparam longint CR_TO_GREEN = coef_fixed(703125);
  localparam longint CB_TO_BLUE  = coef_fixed(1732446);

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_wen = 1'b0;
  logic [yrms_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [yrms_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [yrms_pkg::S_TDATA_W-1:0]   s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [yrms_pkg::M_TDATA_W-1:0]   m_tdata;

  logic [yrms_pkg::MEAN_W-1:0]      mean_red_q, mean_green_q, mean_blue_q;
  logic [yrms_pkg::DIM_CFG_W-1:0]   width_q;

  yrms_pkg::pix_out_t     expected_pixels[$];
  int                     mismatch_count = 0;
  int                     src_idle_pct = 0;
  int                     sink_stall_pct = 0;
  int                     holdoff_req_count = 0;
  int                     holdoff_served = 0;
  int                     holdoff_left = 0;

  yuv_pixel_to_rgb_mean_sub_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [yrms_pkg::PIX_W-1:0] clamp_to_byte(input longint acc);
    longint whole;
    if (acc < 0) return '0;
    whole = acc >>> COEF_FRAC;
    if (whole > 255) return 8'hFF;
    return whole[yrms_pkg::PIX_W-1:0];
  endfunction

  function automatic logic [yrms_pkg::CH_OUT_W-1:0] remove_mean(
    input logic [yrms_pkg::PIX_W-1:0]  ch,
    input logic [yrms_pkg::MEAN_W-1:0] mean
  );
    return {1'b0, ch, 8'h00} - {1'b0, mean};
  endfunction

  function automatic yrms_pkg::pix_out_t predict_pixel(input yrms_pkg::pix_in_t pix);
    longint             luma_q, cb, cr, idx_full;
    yrms_pkg::pix_out_t res;
    luma_q = longint'(pix.luma) << COEF_FRAC;
    cb = longint'(pix.chroma_u) - 128;
    cr = longint'(pix.chroma_v) - 128;
    res.red_out   = remove_mean(clamp_to_byte(luma_q + CR_TO_RED * cr), mean_red_q);
    res.green_out = remove_mean(clamp_to_byte(luma_q - CB_TO_GREEN * cb - CR_TO_GREEN * cr),
                                mean_green_q);
    res.blue_out  = remove_mean(clamp_to_byte(luma_q + CB_TO_BLUE * cb), mean_blue_q);
    idx_full = longint'(pix.target_row) * longint'(width_q) + longint'(pix.target_col);
    res.pixel_index = idx_full[yrms_pkg::IDX_W-1:0];
    return res;
  endfunction

  function automatic yrms_pkg::pix_in_t make_pixel(input int col, input int row, input int y,
                                                   input int u, input int v);
    yrms_pkg::pix_in_t pix;
    pix.target_col = yrms_pkg::COL_W'(col);
    pix.target_row = yrms_pkg::ROW_W'(row);
    pix.luma       = yrms_pkg::PIX_W'(y);
    pix.chroma_u   = yrms_pkg::PIX_W'(u);
    pix.chroma_v   = yrms_pkg::PIX_W'(v);
    return pix;
  endfunction

  function automatic logic [yrms_pkg::PIX_W-1:0] rand_sample();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      default: return yrms_pkg::PIX_W'($urandom);
    endcase
  endfunction

  function automatic yrms_pkg::pix_in_t rand_pixel();
    yrms_pkg::pix_in_t pix;
    pix.target_col = yrms_pkg::COL_W'($urandom_range(2 ** yrms_pkg::COL_W - 1));
    pix.target_row = yrms_pkg::ROW_W'($urandom_range(2 ** yrms_pkg::ROW_W - 1));
    pix.luma       = rand_sample();
    pix.chroma_u   = rand_sample();
    pix.chroma_v   = rand_sample();
    return pix;
  endfunction

  function automatic logic [yrms_pkg::CFG_DATA_W-1:0] rand_mean();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return yrms_pkg::CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [yrms_pkg::CFG_DATA_W-1:0] rand_width();
    case ($urandom_range(7))
      0: return yrms_pkg::CFG_DATA_W'(0);
      1: return yrms_pkg::CFG_DATA_W'(1);
      2: return yrms_pkg::CFG_DATA_W'(MAX_DIM);
      3: return yrms_pkg::CFG_DATA_W'(2 ** yrms_pkg::DIM_CFG_W - 1);
      4: return yrms_pkg::CFG_DATA_W'($urandom);
      5: return yrms_pkg::CFG_DATA_W'($urandom_range(64, 1));
      default: return yrms_pkg::CFG_DATA_W'($urandom_range(MAX_DIM, 1));
    endcase
  endfunction

  always @(posedge clk) begin
    if (holdoff_req_count != holdoff_served) begin
      holdoff_served = holdoff_req_count;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left = holdoff_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    yrms_pkg::pix_out_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[yrms_pkg::M_FIELDS_W-1:0];
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: output transfer with no pending pixel: r=%0d g=%0d b=%0d idx=%0d",
                   $realtime, $signed(got.red_out), $signed(got.green_out),
                   $signed(got.blue_out), got.pixel_index);
      end else begin
        want = expected_pixels.pop_front();
        if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
            got.blue_out !== want.blue_out || got.pixel_index !== want.pixel_index) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"%0t: mismatch exp r=%0d g=%0d b=%0d idx=%0d, ",
                      "got r=%0d g=%0d b=%0d idx=%0d"},
                     $realtime, $signed(want.red_out), $signed(want.green_out),
                     $signed(want.blue_out), want.pixel_index, $signed(got.red_out),
                     $signed(got.green_out), $signed(got.blue_out), got.pixel_index);
        end
      end
    end
  end

  task automatic send_pixel(input yrms_pkg::pix_in_t pix);
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= yrms_pkg::S_TDATA_W'(pix);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_pixels = {expected_pixels, predict_pixel(pix)};
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [yrms_pkg::CFG_IDX_W-1:0] idx,
                           input logic [yrms_pkg::CFG_DATA_W-1:0] val);
    logic [yrms_pkg::DIM_CFG_W-1:0] dim;
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    dim = val[yrms_pkg::DIM_CFG_W-1:0];
    case (idx)
      yrms_pkg::REG_MEAN_RED:      mean_red_q = val;
      yrms_pkg::REG_MEAN_GREEN:    mean_green_q = val;
      yrms_pkg::REG_MEAN_BLUE:     mean_blue_q = val;
      yrms_pkg::REG_TARGET_WIDTH:
        width_q = (dim > MAX_DIM) ? yrms_pkg::DIM_CFG_W'(MAX_DIM) : dim;
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [yrms_pkg::CFG_DATA_W-1:0] mr,
                              input logic [yrms_pkg::CFG_DATA_W-1:0] mg,
                              input logic [yrms_pkg::CFG_DATA_W-1:0] mb,
                              input logic [yrms_pkg::CFG_DATA_W-1:0] w,
                              input logic [yrms_pkg::CFG_DATA_W-1:0] h);
    wait_drained();
    repeat (RESULT_LATENCY) @(posedge clk);
    write_reg(yrms_pkg::REG_MEAN_RED, mr);
    write_reg(yrms_pkg::REG_MEAN_GREEN, mg);
    write_reg(yrms_pkg::REG_MEAN_BLUE, mb);
    write_reg(yrms_pkg::REG_TARGET_WIDTH, w);
    write_reg(yrms_pkg::REG_TARGET_HEIGHT, h);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_values();
    send_pixel(make_pixel(0, 0, 128, 128, 128));
    send_pixel(make_pixel(1023, 1023, 255, 128, 128));
    send_pixel(make_pixel(5, 9, 0, 128, 128));
  endtask

  task automatic test_corner_pixels();
    apply_config(16'h0000, 16'h0000, 16'h0000, yrms_pkg::CFG_DATA_W'(MAX_DIM),
                 yrms_pkg::CFG_DATA_W'(MAX_DIM));
    send_pixel(make_pixel(0, 0, 0, 128, 128));
    send_pixel(make_pixel(1023, 1023, 255, 128, 128));
    send_pixel(make_pixel(1, 2, 0, 0, 0));
    send_pixel(make_pixel(3, 4, 255, 255, 255));
    send_pixel(make_pixel(6, 7, 128, 128, 255));
    send_pixel(make_pixel(8, 9, 128, 128, 0));
    send_pixel(make_pixel(10, 11, 128, 255, 128));
    send_pixel(make_pixel(12, 13, 128, 0, 128));
    send_pixel(make_pixel(14, 15, 0, 255, 255));
    send_pixel(make_pixel(16, 17, 255, 0, 0));
    send_pixel(make_pixel('h2AA, 'h155, 'hAA, 'h55, 'hAA));
    send_pixel(make_pixel('h155, 'h2AA, 'h55, 'hAA, 'h55));
  endtask

  task automatic test_mean_limits();
    apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, yrms_pkg::CFG_DATA_W'(1),
                 yrms_pkg::CFG_DATA_W'(2 ** yrms_pkg::DIM_CFG_W - 1));
    send_pixel(make_pixel(0, 0, 0, 128, 128));
    send_pixel(make_pixel(1023, 1023, 255, 128, 128));
    apply_config(16'h8000, 16'h0001, 16'h7F80, yrms_pkg::CFG_DATA_W'(640),
                 yrms_pkg::CFG_DATA_W'(0));
    send_pixel(make_pixel(639, 479, 200, 90, 170));
    send_pixel(make_pixel(0, 1, 128, 128, 128));
  endtask

  task automatic test_width_limits();
    apply_config(16'h0000, 16'h0000, 16'h0000, yrms_pkg::CFG_DATA_W'(MAX_DIM + 1),
                 yrms_pkg::CFG_DATA_W'(480));
    send_pixel(make_pixel(1023, 1023, 16, 128, 128));
    apply_config(16'h0000, 16'h0000, 16'h0000,
                 yrms_pkg::CFG_DATA_W'(2 ** yrms_pkg::DIM_CFG_W - 1),
                 yrms_pkg::CFG_DATA_W'(480));
    send_pixel(make_pixel(1000, 1023, 16, 128, 128));
    apply_config(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_pixel(make_pixel(1023, 1022, 16, 128, 128));
    apply_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
    send_pixel(make_pixel(777, 1023, 16, 128, 128));
    send_pixel(make_pixel(0, 512, 16, 128, 128));
  endtask

  task automatic test_unknown_registers();
    apply_config(16'h1234, 16'h4321, 16'h0F0F, yrms_pkg::CFG_DATA_W'(100),
                 yrms_pkg::CFG_DATA_W'(100));
    for (int i = FIRST_SPARE_REG; i < 2 ** yrms_pkg::CFG_IDX_W; i++)
      write_reg(yrms_pkg::CFG_IDX_W'(i), 16'hFFFF);
    cfg_wen <= 1'b0;
    @(posedge clk);
    send_pixel(make_pixel(99, 99, 77, 33, 222));
    send_pixel(make_pixel(1023, 1023, 200, 200, 50));
  endtask

  task automatic test_random_traffic();
    int src_mix[4]  = '{0, 50, 0, 7};
    int sink_mix[4] = '{0, 0, 50, 7};
    for (int phase = 0; phase < 4; phase++) begin
      apply_config(rand_mean(), rand_mean(), rand_mean(), rand_width(),
                   yrms_pkg::CFG_DATA_W'($urandom));
      src_idle_pct   = src_mix[phase];
      sink_stall_pct = sink_mix[phase];
      repeat (PHASE_ITEMS) send_pixel(rand_pixel());
    end
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  task automatic test_output_holdoff();
    apply_config(rand_mean(), rand_mean(), rand_mean(), rand_width(),
                 yrms_pkg::CFG_DATA_W'($urandom));
    holdoff_req_count++;
    repeat (40) send_pixel(rand_pixel());
    wait_drained();
    repeat (RESULT_LATENCY) @(posedge clk);
    repeat (20) send_pixel(rand_pixel());
  endtask

  initial begin
    mean_red_q   = '0;
    mean_green_q = '0;
    mean_blue_q  = '0;
    width_q      = yrms_pkg::DIM_CFG_W'(1);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_corner_pixels();
    test_mean_limits();
    test_width_limits();
    test_unknown_registers();
    test_random_traffic();
    test_output_holdoff();
    wait_drained();
    repeat (RESULT_LATENCY * 2) @(posedge clk);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
design/yrms_pkg.sv
design/yuv_pixel_to_rgb_mean_sub_core.sv
sim/tb_top.sv
